// ===== rtl/core/acclp_pkg.sv =====
`default_nettype none

package acclp_pkg;

	// line store geometry
	localparam int LINE_LEN    = 64;
	localparam int STORE_DEPTH = LINE_LEN - 1;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int LEN_W       = $clog2(LINE_LEN);

	// result field widths
	localparam int ID_W      = 32;
	localparam int DLC_W     = 4;
	localparam int PAYLOAD_W = 64;

	// dlc handling: values above the maximum collapse to DLC_OVER
	localparam int DLC_MAX  = 8;
	localparam int DLC_OVER = DLC_MAX + 1;
	localparam int TOK_W    = $clog2(2 * DLC_MAX + 1);

	localparam logic [ID_W-1:0] STD_ID_MASK = 32'h0000_07FF;
	localparam logic [ID_W-1:0] ID_SAT      = 32'hFFFF_FFFF;

	// characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_E     = 8'h45;

	// command prefix "TX:0x", last index
	localparam logic [2:0] PFX_LAST = 3'd4;

	typedef enum logic [1:0] {
		ST_READY    = 2'd0,
		ST_BAD_CMD  = 2'd1,
		ST_BAD_DATA = 2'd2
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    wr_char;
		logic    start;
		logic    advance;
		logic    j_inc;
		logic    j_clr;
		logic    id_acc;
		logic    dlc_acc;
		logic    nib_acc;
		logic    set_ext;
		logic    set_status;
		status_t status_code;
		logic    load_out;
		logic    line_clear;
	} acclp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_term;
		logic line_empty;
		logic ch_end;
		logic ch_space;
		logic ch_hex;
		logic ch_dec;
		logic ch_colon;
		logic ch_e;
		logic pfx_hit;
		logic pfx_last;
		logic tok_full;
	} acclp_stat_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] k);
		logic [7:0] c;
		unique case (k)
			3'd0:    c = 8'h54; // T
			3'd1:    c = 8'h58; // X
			3'd2:    c = 8'h3A; // :
			3'd3:    c = 8'h30; // 0
			3'd4:    c = 8'h78; // x
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
			(c == CH_FF) || (c == CH_CR);
	endfunction

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_dec(c) || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [3:0] v;
		if (is_dec(c)) begin
			v = c[3:0];
		end else begin
			// 'A'..'F' and 'a'..'f' share the low bits 1..6
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/acclp_line_store.sv =====
`default_nettype none

module acclp_line_store (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       wr_en,
	input  wire logic [7:0]                 wr_data,
	input  wire logic                       clear,
	input  wire logic [acclp_pkg::LEN_W-1:0] rd_addr,
	output logic      [7:0]                 rd_data_q,
	output logic      [acclp_pkg::LEN_W-1:0] len_q
);
	import acclp_pkg::*;

	logic [7:0] mem [STORE_DEPTH];
	logic       has_room;

	assign has_room = len_q < LEN_W'(STORE_DEPTH);

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (wr_en && has_room) begin
			mem[len_q[IDX_W-1:0]] <= wr_data;
		end
		if (rd_addr < LEN_W'(STORE_DEPTH)) begin
			rd_data_q <= mem[rd_addr[IDX_W-1:0]];
		end
	end

	// fill count; characters beyond the store are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (clear) begin
			len_q <= '0;
		end else if (wr_en && has_room) begin
			len_q <= len_q + LEN_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/acclp_datapath.sv =====
`default_nettype none

module acclp_datapath (
	input  wire logic                           clk,
	input  wire logic [7:0]                     rx_byte,
	input  wire logic [7:0]                     rd_data,
	input  wire logic [acclp_pkg::LEN_W-1:0]    line_len,
	input  wire acclp_pkg::acclp_cmd_t          cmd,
	output acclp_pkg::acclp_stat_t              stat,
	output logic      [acclp_pkg::LEN_W-1:0]    rd_addr,
	output acclp_pkg::status_t                  out_status_q,
	output logic                                out_is_extended_q,
	output logic      [acclp_pkg::ID_W-1:0]     out_frame_id_q,
	output logic      [acclp_pkg::DLC_W-1:0]    out_data_length_q,
	output logic      [acclp_pkg::PAYLOAD_W-1:0] out_payload_q
);
	import acclp_pkg::*;

	logic [LEN_W-1:0]     p_q;
	logic [TOK_W-1:0]     j_q;
	logic [ID_W-1:0]      id_q;
	logic [DLC_W-1:0]     dlc_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic                 ext_q;
	status_t              status_q;

	logic [DLC_W-1:0]     count;
	logic [6:0]           dlc_sum;
	logic [3:0]           digit;

	assign digit   = hex_val(rd_data);
	assign count   = (dlc_q > DLC_W'(DLC_MAX)) ? DLC_W'(DLC_MAX) : dlc_q;
	assign dlc_sum = {3'b000, dlc_q} * 7'd10 + {3'b000, rd_data[3:0]};

	// next read address; the registered store data answers it in the following cycle
	always_comb begin
		if (cmd.start) begin
			rd_addr = '0;
		end else if (cmd.advance) begin
			rd_addr = p_q + LEN_W'(1);
		end else begin
			rd_addr = p_q;
		end
	end

	always_comb begin
		stat.in_term    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
		stat.line_empty = (line_len == '0);
		stat.ch_end     = (p_q >= line_len) || (rd_data == CH_NUL);
		stat.ch_space   = is_space(rd_data);
		stat.ch_hex     = is_hex(rd_data);
		stat.ch_dec     = is_dec(rd_data);
		stat.ch_colon   = (rd_data == CH_COLON);
		stat.ch_e       = (rd_data == CH_E);
		stat.pfx_hit    = (rd_data == prefix_char(j_q[2:0]));
		stat.pfx_last   = (j_q[2:0] == PFX_LAST);
		stat.tok_full   = (j_q >= {count, 1'b0});
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			p_q       <= '0;
			j_q       <= '0;
			id_q      <= '0;
			dlc_q     <= '0;
			payload_q <= '0;
			ext_q     <= 1'b0;
		end else begin
			if (cmd.advance) begin
				p_q <= p_q + LEN_W'(1);
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + TOK_W'(1);
			end
			if (cmd.id_acc) begin
				// saturate once a digit would push past 32 bits
				if (id_q[ID_W-1:ID_W-4] != 4'd0) begin
					id_q <= ID_SAT;
				end else begin
					id_q <= {id_q[ID_W-5:0], digit};
				end
			end
			if (cmd.dlc_acc && (dlc_q <= DLC_W'(DLC_MAX))) begin
				if (dlc_sum > 7'(DLC_MAX)) begin
					dlc_q <= DLC_W'(DLC_OVER);
				end else begin
					dlc_q <= dlc_sum[DLC_W-1:0];
				end
			end
			if (cmd.nib_acc) begin
				// even nibble is the high half of its byte
				payload_q[{j_q[3:0] ^ 4'd1, 2'b00} +: 4] <= digit;
			end
			if (cmd.set_ext) begin
				ext_q <= 1'b1;
			end
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_code;
		end
		if (cmd.load_out) begin
			out_status_q <= status_q;
			if (status_q == ST_READY) begin
				out_is_extended_q <= ext_q;
				out_frame_id_q    <= ext_q ? id_q : (id_q & STD_ID_MASK);
				out_data_length_q <= count;
				out_payload_q     <= payload_q;
			end else begin
				out_is_extended_q <= 1'b0;
				out_frame_id_q    <= '0;
				out_data_length_q <= '0;
				out_payload_q     <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/acclp_ctrl.sv =====
`default_nettype none

module acclp_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	output logic                        out_valid_q,
	input  wire logic                   out_ready,
	input  wire acclp_pkg::acclp_stat_t stat,
	output acclp_pkg::acclp_cmd_t       cmd
);
	import acclp_pkg::*;

	typedef enum logic [3:0] {
		S_COLLECT,
		S_PREFIX,
		S_ID_SP,
		S_ID,
		S_EXT_CHK,
		S_EXT_COLON,
		S_DLC_SP,
		S_DLC,
		S_TOK_SP,
		S_TOK,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_fire;
	logic   out_free;

	assign in_ready = (state_q == S_COLLECT);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd             = '0;
		cmd.status_code = ST_BAD_CMD;
		state_d         = state_q;
		unique case (state_q)
			S_COLLECT: begin
				if (in_fire) begin
					if (!stat.in_term) begin
						cmd.wr_char = 1'b1;
					end else if (!stat.line_empty) begin
						cmd.start = 1'b1;
						state_d   = S_PREFIX;
					end
				end
			end
			S_PREFIX: begin
				if (!stat.ch_end && stat.pfx_hit) begin
					cmd.advance = 1'b1;
					if (stat.pfx_last) begin
						cmd.j_clr = 1'b1;
						state_d   = S_ID_SP;
					end else begin
						cmd.j_inc = 1'b1;
					end
				end else begin
					cmd.set_status = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_ID_SP: begin
				priority if (stat.ch_end) begin
					cmd.set_status = 1'b1;
					state_d        = S_DONE;
				end else if (stat.ch_space) begin
					cmd.advance = 1'b1;
				end else if (stat.ch_hex) begin
					cmd.advance = 1'b1;
					cmd.id_acc  = 1'b1;
					state_d     = S_ID;
				end else begin
					cmd.set_status = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_ID: begin
				priority if (stat.ch_end) begin
					cmd.set_status = 1'b1;
					state_d        = S_DONE;
				end else if (stat.ch_hex) begin
					cmd.advance = 1'b1;
					cmd.id_acc  = 1'b1;
				end else if (stat.ch_colon) begin
					cmd.advance = 1'b1;
					state_d     = S_EXT_CHK;
				end else begin
					cmd.set_status = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_EXT_CHK: begin
				// an 'E' here can only belong to the extended form
				if (!stat.ch_end && stat.ch_e) begin
					cmd.advance = 1'b1;
					cmd.set_ext = 1'b1;
					state_d     = S_EXT_COLON;
				end else begin
					state_d = S_DLC_SP;
				end
			end
			S_EXT_COLON: begin
				if (!stat.ch_end && stat.ch_colon) begin
					cmd.advance = 1'b1;
					state_d     = S_DLC_SP;
				end else begin
					cmd.set_status = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_DLC_SP: begin
				priority if (stat.ch_end) begin
					cmd.set_status = 1'b1;
					state_d        = S_DONE;
				end else if (stat.ch_space) begin
					cmd.advance = 1'b1;
				end else if (stat.ch_dec) begin
					cmd.advance = 1'b1;
					cmd.dlc_acc = 1'b1;
					state_d     = S_DLC;
				end else begin
					cmd.set_status = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_DLC: begin
				priority if (stat.ch_end) begin
					cmd.set_status = 1'b1;
					state_d        = S_DONE;
				end else if (stat.ch_dec) begin
					cmd.advance = 1'b1;
					cmd.dlc_acc = 1'b1;
				end else if (stat.ch_colon) begin
					cmd.advance = 1'b1;
					state_d     = S_TOK_SP;
				end else begin
					cmd.set_status = 1'b1;
					state_d        = S_DONE;
				end
			end
			S_TOK_SP: begin
				priority if (stat.ch_end) begin
					cmd.set_status = 1'b1;
					state_d        = S_DONE;
				end else if (stat.ch_space) begin
					cmd.advance = 1'b1;
				end else begin
					state_d = S_TOK;
				end
			end
			S_TOK: begin
				priority if (stat.tok_full) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_READY;
					state_d         = S_DONE;
				end else if (stat.ch_end || stat.ch_space || !stat.ch_hex) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_BAD_DATA;
					state_d         = S_DONE;
				end else begin
					cmd.advance = 1'b1;
					cmd.nib_acc = 1'b1;
					cmd.j_inc   = 1'b1;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out   = 1'b1;
					cmd.line_clear = 1'b1;
					state_d        = S_COLLECT;
				end
			end
			default: begin
				state_d = S_COLLECT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ascii_can_command_line_parser.sv =====
// ASCII CAN command line parser. Received characters arrive one per item on the s_axis side
// and are collected into a 63-character line store; characters beyond that are dropped. A CR
// or LF closes the line: an empty line gives nothing, otherwise the line is parsed as
// "TX:0x<hex id>:E:<dec dlc>:<hex data>" (extended) or "TX:0x<hex id>:<dec dlc>:<hex data>"
// (standard) and exactly one result item leaves on the m_axis side with status 0 frame ready,
// 1 bad command or 2 bad data. A standard id is masked to 11 bits, dlc is clamped to 8,
// numbers saturate at 0xFFFFFFFF, and on an error every field but status is zero. Ordinary
// characters are taken at one per cycle. After a terminator the parser walks the stored line
// one character per cycle through the single read port of the line store; the input stays
// blocked during that walk and while a previous result sits unread in the output register.
// The store needs no initialization after reset.

`default_nettype none

module ascii_can_command_line_parser (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // [7:0] rx_byte
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic      [103:0] m_axis_tdata,  // [31:0] frame_id, [35:32] data_length,
	                                         // [99:36] payload, [103:100] zero
	output logic      [2:0]   m_axis_tuser   // [1:0] status, [2] is_extended
);
	import acclp_pkg::*;

	acclp_cmd_t             cmd;
	acclp_stat_t            stat;
	logic [LEN_W-1:0]       rd_addr;
	logic [LEN_W-1:0]       line_len;
	logic [7:0]             rd_data;
	status_t                out_status;
	logic                   out_is_extended;
	logic [ID_W-1:0]        out_frame_id;
	logic [DLC_W-1:0]       out_data_length;
	logic [PAYLOAD_W-1:0]   out_payload;

	// sequencer: collects characters, then steps the parse one character a cycle
	acclp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.out_valid_q (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.stat        (stat),
		.cmd         (cmd)
	);

	// line store with its fill count; read data comes back registered
	acclp_line_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cmd.wr_char),
		.wr_data   (s_axis_tdata),
		.clear     (cmd.line_clear),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data),
		.len_q     (line_len)
	);

	// read pointer, id/dlc/payload accumulators, character classes and result register
	acclp_datapath u_dp (
		.clk               (clk),
		.rx_byte           (s_axis_tdata),
		.rd_data           (rd_data),
		.line_len          (line_len),
		.cmd               (cmd),
		.stat              (stat),
		.rd_addr           (rd_addr),
		.out_status_q      (out_status),
		.out_is_extended_q (out_is_extended),
		.out_frame_id_q    (out_frame_id),
		.out_data_length_q (out_data_length),
		.out_payload_q     (out_payload)
	);

	// result item packing
	assign m_axis_tdata = {4'b0000, out_payload, out_data_length, out_frame_id};
	assign m_axis_tuser = {out_is_extended, out_status};

endmodule

`default_nettype wire

// ===== rtl/core/acclp_checker.sv =====
`default_nettype none

module acclp_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [103:0] m_axis_tdata,
	input wire logic [2:0]   m_axis_tuser
);
	import acclp_pkg::*;

	// a pending result is not withdrawn
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped before it was taken");

	// only the three defined status codes appear
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[1:0] == ST_READY) ||
			(m_axis_tuser[1:0] == ST_BAD_CMD) || (m_axis_tuser[1:0] == ST_BAD_DATA))
		else $error("undefined status code");

	// error results carry no frame content
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] != ST_READY) |->
			(m_axis_tdata == '0) && !m_axis_tuser[2])
		else $error("error result with nonzero fields");

	// standard id fits 11 bits
	a_std_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] == ST_READY) && !m_axis_tuser[2] |->
			(m_axis_tdata[31:11] == '0))
		else $error("standard id wider than 11 bits");

	// data length clamped and unused payload bytes zero
	a_dlc: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[1:0] == ST_READY) |->
			(m_axis_tdata[35:32] <= 4'(DLC_MAX)) &&
			((m_axis_tdata[99:36] >> ({2'b00, m_axis_tdata[35:32]} * 7'd8)) == '0))
		else $error("data length above 8 or stray payload bits");

endmodule

bind ascii_can_command_line_parser acclp_checker u_acclp_checker (.*);

`default_nettype wire

// ===== sim/acclp_frame_checker.sv =====
`default_nettype none

module acclp_frame_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [103:0] m_axis_tdata,   // [31:0] id, [35:32] dlc, [99:36] payload
	input  wire logic [2:0]   m_axis_tuser,   // [1:0] status, [2] is_extended
	output int                fail_count,
	output int                frames_pending
);
	import acclp_pkg::*;

	typedef struct packed {
		status_t                status;
		logic                   is_ext;
		logic [ID_W-1:0]        id;
		logic [DLC_W-1:0]       len;
		logic [PAYLOAD_W-1:0]   data;
	} frame_t;

	// shadow copy of the line being collected
	logic [7:0] line_chars [STORE_DEPTH];
	int         line_fill;
	frame_t     frame_q [$];

	// parser scratch: cursor, last number read, located form fields
	int              scan_pos;
	logic [ID_W-1:0] num_val;
	logic [ID_W-1:0] form_id;
	logic [ID_W-1:0] form_dlc;
	int              tok_at;
	int              tok_len;

	function automatic int nibble_of(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 48;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 55;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 87;
		return -1;
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
			c == CH_FF || c == CH_CR;
	endfunction

	function automatic void skip_blanks(int n);
		while (scan_pos < n && is_blank(line_chars[scan_pos])) scan_pos++;
	endfunction

	function automatic bit match_text(string s, int n);
		for (int k = 0; k < s.len(); k++) begin
			if (scan_pos >= n || line_chars[scan_pos] != s[k]) return 0;
			scan_pos++;
		end
		return 1;
	endfunction

	// unsigned number with saturation at all ones
	function automatic bit read_number(int base, int n);
		logic [63:0] acc;
		int          d;
		bit          any;
		acc = '0;
		any = 0;
		skip_blanks(n);
		while (scan_pos < n) begin
			d = nibble_of(line_chars[scan_pos]);
			if (d < 0 || d >= base) break;
			acc = acc * base + d;
			if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
			any = 1;
			scan_pos++;
		end
		num_val = acc[31:0];
		return any;
	endfunction

	function automatic bit match_form(bit ext, int n);
		int len;
		scan_pos = 0;
		if (!match_text("TX:0x", n)) return 0;
		if (!read_number(16, n)) return 0;
		form_id = num_val;
		if (ext && !match_text(":E:", n)) return 0;
		if (!ext && !match_text(":", n)) return 0;
		if (!read_number(10, n)) return 0;
		form_dlc = num_val;
		if (!match_text(":", n)) return 0;
		skip_blanks(n);
		len = 0;
		while (scan_pos + len < n && len < 16 && !is_blank(line_chars[scan_pos + len])) len++;
		if (len == 0) return 0;
		tok_at  = scan_pos;
		tok_len = len;
		return 1;
	endfunction

	function automatic frame_t predict_frame(int n);
		frame_t          f;
		logic [63:0]     bytes_acc;
		int              count;
		int              hi;
		int              lo;
		bit              ext;
		f         = '0;
		f.status  = ST_BAD_CMD;
		bytes_acc = '0;
		ext       = 1;
		if (!match_form(1, n)) begin
			ext = 0;
			if (!match_form(0, n)) return f;
			form_id = form_id & STD_ID_MASK;
		end
		count = (form_dlc > 32'(DLC_MAX)) ? DLC_MAX : int'(form_dlc);
		for (int i = 0; i < count; i++) begin
			if (2 * i + 1 >= tok_len) begin
				f.status = ST_BAD_DATA;
				return f;
			end
			hi = nibble_of(line_chars[tok_at + 2 * i]);
			lo = nibble_of(line_chars[tok_at + 2 * i + 1]);
			if (hi < 0 || lo < 0) begin
				f.status = ST_BAD_DATA;
				return f;
			end
			bytes_acc[8 * i +: 8] = 8'(hi * 16 + lo);
		end
		f.status = ST_READY;
		f.is_ext = ext;
		f.id     = form_id;
		f.len    = 4'(count);
		f.data   = bytes_acc;
		return f;
	endfunction

	task automatic check_field(string what, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		frame_t want;
		int     n;
		if (!arst_n) begin
			line_fill  = 0;
			fail_count = 0;
			frame_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (frame_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, got tuser %h tdata %h",
						$time, m_axis_tuser, m_axis_tdata);
					fail_count++;
				end else begin
					want = frame_q.pop_front();
					check_field("status", want.status, m_axis_tuser[1:0]);
					check_field("is_extended", want.is_ext, m_axis_tuser[2]);
					check_field("frame_id", want.id, m_axis_tdata[31:0]);
					check_field("data_length", want.len, m_axis_tdata[35:32]);
					check_field("payload", want.data, m_axis_tdata[99:36]);
					check_field("tdata pad", '0, m_axis_tdata[103:100]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tdata != CH_LF && s_axis_tdata != CH_CR) begin
					if (line_fill < STORE_DEPTH) begin
						line_chars[line_fill] = s_axis_tdata;
						line_fill++;
					end
				end else if (line_fill != 0) begin
					// the line effectively ends at the first nul
					n = 0;
					while (n < line_fill && line_chars[n] != CH_NUL) n++;
					line_fill = 0;
					frame_q.push_back(predict_frame(n));
				end
			end
		end
		frames_pending = frame_q.size();
	end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
	import acclp_pkg::*;

	typedef enum int {
		RX_OPEN,
		RX_CHOPPY,
		RX_STARVED
	} rx_mode_t;

	logic         clk           = 1'b0;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic [7:0]   s_axis_tdata  = 8'h00;
	logic         m_axis_tready = 1'b0;
	logic         s_axis_tready;
	logic         m_axis_tvalid;
	logic [103:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	int           fail_count;
	int           frames_pending;

	logic [7:0] char_q [$];    // characters still to send
	logic [7:0] line_buf [$];  // line under construction

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	ascii_can_command_line_parser dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	acclp_frame_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.fail_count     (fail_count),
		.frames_pending (frames_pending)
	);

	// sender: bursts of random length with random gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
			burst_left = 0;
			gap_left   = 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left > 0 || char_q.size() == 0) begin
				if (gap_left > 0) gap_left--;
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= char_q.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// receiver: stall pattern switches between open, choppy and starved stretches
	rx_mode_t rx_mode;
	int       rx_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_mode = RX_OPEN;
			rx_left = 0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				rx_left = $urandom_range(20, 300);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_OPEN:   m_axis_tready <= 1'b1;
				RX_CHOPPY: m_axis_tready <= 1'($urandom_range(0, 1));
				default:   m_axis_tready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	task automatic put_char(logic [7:0] c);
		line_buf.push_back(c);
	endtask

	task automatic put_text(string s);
		for (int k = 0; k < s.len(); k++) line_buf.push_back(s[k]);
	endtask

	task automatic put_hex(int digits);
		int v;
		for (int k = 0; k < digits; k++) begin
			v = $urandom_range(0, 15);
			if (v < 10) put_char(8'(48 + v));
			else put_char(8'(($urandom_range(0, 1) ? 65 : 97) + v - 10));
		end
	endtask

	task automatic put_blanks();
		int count;
		count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(0, 3))
				0:       put_char(CH_SPACE);
				1:       put_char(CH_TAB);
				2:       put_char(CH_VT);
				default: put_char(CH_FF);
			endcase
		end
	endtask

	task automatic put_noise(int len);
		for (int k = 0; k < len; k++) put_char(8'($urandom_range(0, 255)));
	endtask

	// move the line to the send queue with a terminator, optionally corrupting one char
	task automatic commit_line(bit mangle);
		int k;
		if (mangle && line_buf.size() > 0 && $urandom_range(0, 7) == 0) begin
			k = $urandom_range(0, line_buf.size() - 1);
			line_buf[k] = 8'($urandom_range(0, 255));
		end
		foreach (line_buf[i]) char_q.push_back(line_buf[i]);
		line_buf.delete();
		case ($urandom_range(0, 3))
			0:       char_q.push_back(CH_CR);
			1:       char_q.push_back(CH_LF);
			2: begin
				char_q.push_back(CH_CR);
				char_q.push_back(CH_LF);
			end
			default: begin
				char_q.push_back(CH_LF);
				char_q.push_back(CH_CR);
			end
		endcase
	endtask

	// well-formed command skeleton with random content and occasional defects
	task automatic put_command();
		int dlc;
		int digits;
		put_text("TX:0x");
		put_blanks();
		put_hex(($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 8));
		if ($urandom_range(0, 1)) put_text(":E:");
		else put_char(CH_COLON);
		put_blanks();
		case ($urandom_range(0, 11))
			0: dlc = $urandom_range(9, 15);
			1: begin
				// saturating dlc
				dlc = 8;
				for (int k = 0; k < 11; k++) put_char(8'(48 + $urandom_range(0, 9)));
			end
			2: dlc = -1;
			default: dlc = $urandom_range(0, 8);
		endcase
		if (dlc >= 0 && dlc != 8) put_text($sformatf("%0d", dlc));
		else if (dlc == 8 && $urandom_range(0, 1)) put_text("8");
		if (dlc < 0) dlc = 2;
		put_char(CH_COLON);
		put_blanks();
		digits = 2 * ((dlc > 8) ? 8 : dlc);
		case ($urandom_range(0, 7))
			0: digits = (digits > 0) ? digits - 1 : 0;
			1: digits = digits + $urandom_range(1, 6);
			default: ;
		endcase
		put_hex(digits);
		if (digits == 0 && $urandom_range(0, 1)) put_char(8'h5A);
		if ($urandom_range(0, 5) == 0) begin
			put_char(CH_SPACE);
			put_hex($urandom_range(1, 6));
		end
		// push some lines past the store capacity
		if ($urandom_range(0, 15) == 0) put_noise($urandom_range(30, 50));
	endtask

	initial begin
		// directed lines
		put_text("TX:0x123:8:0011223344556677");
		commit_line(0);
		put_text("TX:0x1ABCDEF0:E:2:aBcD");
		commit_line(0);
		char_q.push_back(CH_CR);
		put_text("TX:0xFFF:0:Z");
		commit_line(0);
		put_text("TX:0x7ff:12:0102030405060708FF");
		commit_line(0);
		put_text("TX:0x123456789:E:99999999999:00112233445566778899");
		commit_line(0);
		put_text("TX:0x");
		put_char(CH_TAB);
		put_text("10:");
		put_char(CH_VT);
		put_text("3:");
		put_char(CH_FF);
		put_text("12 34");
		commit_line(0);
		put_text("TX:0x10:3:");
		commit_line(0);
		put_text("TX:0x:1:00");
		commit_line(0);
		put_text("TX:0x5:E:1:0G");
		commit_line(0);
		put_text("TX:0x5:1:A");
		put_char(CH_NUL);
		put_text("B");
		commit_line(0);
		put_text("tx:0x5:1:AB");
		commit_line(0);
		put_text("TX:0x0x5:1:AB");
		commit_line(0);
		put_text("TX:0x42:1:5A");
		for (int k = 0; k < 70; k++) put_char(8'hFF);
		commit_line(0);

		// random part
		while (char_q.size() < 1550) begin
			case ($urandom_range(0, 19))
				0, 1: put_noise($urandom_range(0, 80));
				2, 3: begin
					put_text("TX:0x");
					put_noise($urandom_range(0, 20));
				end
				default: put_command();
			endcase
			commit_line(1);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (char_q.size() != 0 || s_axis_tvalid);
		while (frames_pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
